// ===== rtl/core/integer_to_ascii_radix_defines.svh =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_defines
// assertion macros shared by the integer to ascii converter
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ITOA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, constants and helpers of the integer to ascii converter
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned DIG_DEPTH   = 32;
    localparam int unsigned DIG_IDX_W   = 5;
    localparam int unsigned DIG_CNT_W   = 6;
    localparam int unsigned BITS_PER_STEP = 8;
    localparam int unsigned STEP_W      = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

    localparam logic [STEP_W-1:0]  STEP_LAST = 2'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_TEN   = 8'd10;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic div;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic quot_zero;
        logic neg;
        logic last_digit;
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] v_d;
        v_d = CHAR_W'(d);
        if (d > DIGIT_MAX) begin
            return CHAR_A + v_d - CHAR_TEN;
        end
        return CHAR_ZERO + v_d;
    endfunction

endpackage

// ===== rtl/core/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl
// sequencer: accept, digit division steps, sign and digit emission
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_defines.svh"

module itoa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  itoa_pkg::t_sts   i_sts,
    output itoa_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [itoa_pkg::STEP_W-1:0]  r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_step    = r_step + 1'b1;
                if (r_step == itoa_pkg::STEP_LAST) begin
                    o_cmd.push = 1'b1;
                    if (i_sts.quot_zero) begin
                        n_state = i_sts.neg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    `ITOA_ASSERT_IMPL(a_emit_when_free, o_cmd.emit_sign || o_cmd.emit_digit, i_sts.out_free, "emit while output busy")
    `ITOA_ASSERT_NEXT(a_start_to_div, o_cmd.start, (r_state == ST_DIV) && (r_step == '0), "start did not enter division")

endmodule

// ===== rtl/core/itoa_dp.sv =====
// ----------------------------------------------------------------------------
// itoa_dp
// magnitude register, 8-bit-per-cycle radix divider, digit stack, output word
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_defines.svh"

module itoa_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  itoa_pkg::t_cmd                     i_cmd,
    input  logic signed [itoa_pkg::VALUE_W-1:0] i_value,
    input  logic [itoa_pkg::RADIX_W-1:0]       i_radix,
    input  logic                               i_out_stall,
    output itoa_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    output logic [itoa_pkg::CHAR_W-1:0]        o_character,
    output logic                               o_last
);

    logic [itoa_pkg::VALUE_W-1:0]   r_work, n_work;
    logic [itoa_pkg::DIGIT_W-1:0]   r_rem, n_rem;
    logic [itoa_pkg::RADIX_W-1:0]   r_base, n_base;
    logic                           r_neg, n_neg;
    logic [itoa_pkg::DIG_CNT_W-1:0] r_ndig;
    logic [itoa_pkg::DIGIT_W-1:0]   r_digit [itoa_pkg::DIG_DEPTH];
    logic [itoa_pkg::DIG_IDX_W-1:0] rd_idx;
    logic [itoa_pkg::VALUE_W-1:0]   mag;
    logic                           r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]    r_char;
    logic                           r_last;
    logic                           out_free;

    // radix saturation and magnitude of the incoming word
    always_comb begin
        if (i_radix < itoa_pkg::RADIX_MIN) begin
            n_base = itoa_pkg::RADIX_MIN;
        end else if (i_radix > itoa_pkg::RADIX_MAX) begin
            n_base = itoa_pkg::RADIX_MAX;
        end else begin
            n_base = i_radix;
        end
        n_neg = (n_base == itoa_pkg::RADIX_DEC) && i_value[itoa_pkg::VALUE_W-1];
        mag   = n_neg ? (~i_value + 1'b1) : i_value;
    end

    // restoring division, one byte of quotient bits a cycle
    always_comb begin
        logic [itoa_pkg::DIGIT_W:0]   v_rem;
        logic [itoa_pkg::VALUE_W-1:0] v_work;
        v_rem  = {1'b0, r_rem};
        v_work = r_work;
        for (int j = 0; j < itoa_pkg::BITS_PER_STEP; j++) begin
            v_rem  = {v_rem[itoa_pkg::DIGIT_W-1:0], v_work[itoa_pkg::VALUE_W-1]};
            v_work = {v_work[itoa_pkg::VALUE_W-2:0], 1'b0};
            if (v_rem >= r_base) begin
                v_rem     = v_rem - r_base;
                v_work[0] = 1'b1;
            end
        end
        n_work = v_work;
        n_rem  = v_rem[itoa_pkg::DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_work <= mag;
            r_rem  <= '0;
            r_base <= n_base;
            r_neg  <= n_neg;
        end else if (i_cmd.div) begin
            r_work <= n_work;
            r_rem  <= i_cmd.push ? '0 : n_rem;
        end
    end

    // digit stack, least significant pushed first
    assign rd_idx = r_ndig[itoa_pkg::DIG_IDX_W-1:0] - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_digit[r_ndig[itoa_pkg::DIG_IDX_W-1:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig <= '0;
        end else if (i_cmd.start) begin
            r_ndig <= '0;
        end else if (i_cmd.push) begin
            r_ndig <= r_ndig + 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_ndig <= r_ndig - 1'b1;
        end
    end

    // output word register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= itoa_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= itoa_pkg::digit_to_ascii(r_digit[rd_idx]);
            r_last <= (r_ndig == itoa_pkg::DIG_CNT_W'(1));
        end
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.quot_zero  = (n_work == '0);
    assign o_sts.neg        = r_neg;
    assign o_sts.last_digit = (r_ndig == itoa_pkg::DIG_CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    `ITOA_ASSERT_IMPL(a_push_room, i_cmd.push, r_ndig < itoa_pkg::DIG_CNT_W'(itoa_pkg::DIG_DEPTH), "digit stack overflow")
    `ITOA_ASSERT_IMPL(a_pop_nonempty, i_cmd.emit_digit, r_ndig != '0, "digit stack underflow")

endmodule

// ===== rtl/core/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// converts a 32-bit integer to ascii characters in radix 2 to 16
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 word
//  in       sink       i_in_valid / o_in_stall   i_value, i_radix
//  out      source     o_out_valid / i_out_stall o_character, o_last
//
//  one number at a time; after acceptance the divider works through the
//  whole 32-bit magnitude for each digit (8 quotient bits a cycle), then
//  the optional sign and the digits go out through the output register
//  reset is synchronous, active low, and clears control state only
//  a stalled output only holds emission; o_in_stall drops once the last
//  character is in the output register, so the next number can start
//  while that character still waits to be taken
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [itoa_pkg::VALUE_W-1:0] i_value,
    input  logic [itoa_pkg::RADIX_W-1:0]        i_radix,
    // output words
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last
);

    // command and status between sequencer and datapath
    itoa_pkg::t_cmd cmd;
    itoa_pkg::t_sts sts;

    // sequencer: idle, divide, optional sign, digits most significant first
    itoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: magnitude, divider, digit stack and output word register
    itoa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ===== tb/sv/integer_to_ascii_radix_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb
// self-checking bench for the integer to ascii converter: a short table of
// known numbers, then random numbers and radices, every character compared
// in order against the table's spelling or a behavioural spelling of the number
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;

    // run shape
    localparam int ITEM_COUNT   = 460;   // input words in total, table included
    localparam int QUIET_TAIL   = 60;    // last words sent with no idling at all
    localparam int HOLD_AT      = 140;   // word index that arms the long output hold
    localparam int HOLD_CYCLES  = 300;   // length of that hold, in cycles
    localparam int PAUSE_AT     = 300;   // word index where the sender drains the block
    localparam int DRAIN_CYCLES = 200;   // settle time after the last character
    localparam int STALL_LIMIT  = 3000;  // cycles with no word moving before giving up
    localparam int REPORT_MAX   = 10;

    // one expected character of the output stream
    typedef struct packed {
        logic [itoa_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_char_word;

    // a table row; an empty spelling means the predictor supplies it
    typedef struct {
        logic [itoa_pkg::VALUE_W-1:0] value;
        logic [itoa_pkg::RADIX_W-1:0] radix;
        string                        spelled;
    } t_known_number;

    localparam int N_KNOWN = 24;

    t_known_number known_numbers [N_KNOWN] = '{
        '{32'd0,          5'd10, "0"},
        '{32'd0,          5'd2,  "0"},
        '{32'd0,          5'd16, "0"},
        '{32'h8000_0000,  5'd10, "-2147483648"},
        '{32'h7FFF_FFFF,  5'd10, "2147483647"},
        '{32'hFFFF_FFFF,  5'd10, "-1"},
        '{32'hFFFF_FFFF,  5'd16, "FFFFFFFF"},
        '{32'hFFFF_FFFF,  5'd2,  "11111111111111111111111111111111"},
        '{32'h8000_0000,  5'd2,  "10000000000000000000000000000000"},
        '{32'h8000_0000,  5'd16, "80000000"},
        '{32'hABCD_EF01,  5'd16, "ABCDEF01"},
        '{32'd9,          5'd10, "9"},
        '{32'd10,         5'd16, "A"},
        '{32'd15,         5'd16, "F"},
        '{32'd5,          5'd0,  "101"},
        '{32'd5,          5'd1,  "101"},
        '{32'd255,        5'd17, "FF"},
        '{32'd255,        5'd31, "FF"},
        '{32'd12345,      5'd10, "12345"},
        '{32'hFFFF_FFF9,  5'd8,  ""},
        '{32'h7FFF_FFFF,  5'd3,  ""},
        '{32'hFFFF_FFFF,  5'd7,  ""},
        '{32'h1234_5678,  5'd13, ""},
        '{32'hDEAD_BEEF,  5'd15, ""}
    };

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_stall;
    logic signed [itoa_pkg::VALUE_W-1:0] i_value     = '0;
    logic [itoa_pkg::RADIX_W-1:0]        i_radix     = itoa_pkg::RADIX_MIN;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [itoa_pkg::CHAR_W-1:0]         o_character;
    logic                                o_last;

    t_char_word pending_chars [$];   // characters still owed by the block
    int         mismatches  = 0;
    bit         quiet_mode  = 1'b0;  // set by the sender; both sides stop idling
    bit         hold_armed  = 1'b0;  // sender asks the receiver for the long hold

    integer_to_ascii_radix DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // spell one number the way the block should, appending to the pending stream
    // radix is saturated into 2..16; only radix ten treats the top bit as a sign
    function automatic void spell_number(input logic [itoa_pkg::VALUE_W-1:0] bits,
                                         input logic [itoa_pkg::RADIX_W-1:0] radix);
        logic [itoa_pkg::RADIX_W-1:0] base;
        logic [itoa_pkg::VALUE_W-1:0] mag;
        logic [itoa_pkg::VALUE_W-1:0] rem;
        logic [itoa_pkg::CHAR_W-1:0]  digits [$];
        bit                           neg;
        if (radix < itoa_pkg::RADIX_MIN)
            base = itoa_pkg::RADIX_MIN;
        else if (radix > itoa_pkg::RADIX_MAX)
            base = itoa_pkg::RADIX_MAX;
        else
            base = radix;
        neg  = (base == itoa_pkg::RADIX_DEC) && bits[itoa_pkg::VALUE_W-1];
        // unsigned two's complement negation keeps the most negative value exact
        mag  = neg ? (~bits + 1'b1) : bits;
        if (mag == '0) begin
            pending_chars.push_back('{itoa_pkg::CHAR_ZERO, 1'b1});
            return;
        end
        while (mag != '0) begin
            rem = mag % itoa_pkg::VALUE_W'(base);
            if (rem > itoa_pkg::VALUE_W'(itoa_pkg::DIGIT_MAX))
                digits.push_front(itoa_pkg::CHAR_A + itoa_pkg::CHAR_W'(rem)
                                  - itoa_pkg::CHAR_TEN);
            else
                digits.push_front(itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(rem));
            mag = mag / itoa_pkg::VALUE_W'(base);
        end
        if (neg)
            pending_chars.push_back('{itoa_pkg::CHAR_MINUS, 1'b0});
        foreach (digits[i])
            pending_chars.push_back('{digits[i], i == digits.size() - 1});
    endfunction

    // random value: whole range, small magnitudes either side, extremes and
    // right-shifted words so the digit count spreads out
    function automatic logic [itoa_pkg::VALUE_W-1:0] draw_value();
        logic [itoa_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2: v = -$urandom_range(0, 20);
            3: v = $urandom >> $urandom_range(0, 31);
            4: v = -($urandom >> $urandom_range(0, 31));
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // mostly legal radices, decimal favoured for the sign path, sometimes any code
    function automatic logic [itoa_pkg::RADIX_W-1:0] draw_radix();
        case ($urandom_range(0, 9))
            0, 1: return itoa_pkg::RADIX_DEC;
            2:    return itoa_pkg::RADIX_W'($urandom_range(0, 31));
            default: return itoa_pkg::RADIX_W'($urandom_range(2, 16));
        endcase
    endfunction

    // present one word and hold it until taken; the expectation is logged on
    // the edge that accepts it
    task automatic offer_number(input logic [itoa_pkg::VALUE_W-1:0] value,
                                input logic [itoa_pkg::RADIX_W-1:0] radix,
                                input string                        spelled);
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_radix    <= radix;
        do @(posedge i_clk); while (o_in_stall);
        if (spelled.len() == 0) begin
            spell_number(value, radix);
        end else begin
            for (int i = 0; i < spelled.len(); i++)
                pending_chars.push_back('{spelled[i], i == spelled.len() - 1});
        end
    endtask

    // sender: table first, then random words, with gaps, one drain pause,
    // and a trigger for the long output hold
    initial begin : sender
        logic [itoa_pkg::VALUE_W-1:0] value;
        logic [itoa_pkg::RADIX_W-1:0] radix;
        string                        spelled;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < ITEM_COUNT; idx++) begin
            // calm stretches every so often, and a quiet tail to finish
            quiet_mode = (idx >= ITEM_COUNT - QUIET_TAIL) || ((idx / 50) % 4 == 3);
            if (idx == HOLD_AT)
                hold_armed = 1'b1;

            if (idx < N_KNOWN) begin
                value   = known_numbers[idx].value;
                radix   = known_numbers[idx].radix;
                spelled = known_numbers[idx].spelled;
            end else begin
                value   = draw_value();
                radix   = draw_radix();
                spelled = "";
            end

            if (idx == PAUSE_AT) begin
                // let the block run completely dry before going on
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_chars.size() != 0);
            end else if (!quiet_mode && $urandom_range(0, 2) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            offer_number(value, radix, spelled);
        end
        i_in_valid <= 1'b0;

        // everything sent: wait for the stream to empty, then watch for strays
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // compare one accepted character with the oldest expected one
    task automatic check_char(input logic [itoa_pkg::CHAR_W-1:0] ch, input logic last);
        t_char_word want;
        if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected character %h last %b", ch, last);
        end else begin
            want = pending_chars.pop_front();
            if (want.ch !== ch || want.last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("character mismatch: expected %h last %b, got %h last %b",
                             want.ch, want.last, ch, last);
            end
        end
    endtask

    // receiver: samples the output word on each edge, then decides the next stall
    initial begin : receiver
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                check_char(o_character, o_last);

            if (hold_armed) begin
                // long hold so the block backs up and stalls its input
                hold_armed = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                burst = 0;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog: gives up when no word moves on either side for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/itoa_pkg.sv
rtl/core/itoa_ctrl.sv
rtl/core/itoa_dp.sv
rtl/core/integer_to_ascii_radix.sv
tb/sv/integer_to_ascii_radix_tb.sv
